@@ rtl/gvap_pkg.sv @@
package gvap_pkg;

    // Aperture law constants (0.1 degree and 0.1 percent units)
    localparam int START_C10 = 15;
    localparam int FULL_C10  = 35;
    localparam int APER_SPAN = FULL_C10 - START_C10;
    localparam int APER_GAIN = 1000 / APER_SPAN;

    localparam logic [9:0]         APER_FULL  = 10'd1000;
    localparam logic signed [11:0] POS_MAX    = 12'sd1000;
    localparam logic signed [10:0] MOVE_MIN   = 11'sd100;
    localparam logic signed [10:0] STEP_MAX   = 11'sd250;
    localparam logic [23:0]        HOLD_MS    = 24'd600000;
    localparam logic [23:0]        STALE_MS   = 24'd90000;
    localparam logic [10:0]        TARGET_NONE = 11'h7FF;

    // Vent action codes
    localparam logic [1:0] ACT_STEPPED = 2'd0;
    localparam logic [1:0] ACT_HOLD    = 2'd1;
    localparam logic [1:0] ACT_DRIVE   = 2'd2;

    // Humidity demand codes
    localparam logic [1:0] HUM_NONE    = 2'd0;
    localparam logic [1:0] HUM_PARTIAL = 2'd1;

    // Window state codes
    localparam logic [1:0] WIN_UNKNOWN = 2'd0;
    localparam logic [1:0] WIN_REST    = 2'd1;

    // Last drive result codes
    localparam logic [1:0] RES_TIMEOUT = 2'd1;
    localparam logic [1:0] RES_ABORTED = 2'd2;

    // Law step from which the demand applies
    localparam logic [2:0] STEP_ACTIVE = 3'd2;

    // Reason flag bit positions
    localparam int FL_DIGITAL = 0;
    localparam int FL_NO_POS  = 1;
    localparam int FL_HELD    = 2;
    localparam int FL_REBASED = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMP_MAX = 2'd0;
    localparam logic [1:0] CFG_DEADZONE = 2'd1;

    localparam logic signed [11:0] TEMP_MAX_RESET = 12'sd250;

    typedef struct packed {
        logic               temp_valid;
        logic signed [11:0] temp_avg_c10;
        logic [2:0]         law_step;
        logic [1:0]         humid_demand;
        logic               vent_linear;
        logic signed [11:0] pos_x10;
        logic [23:0]        report_age_ms;
        logic [1:0]         window_state;
        logic [1:0]         drive_outcome;
        logic [23:0]        since_drive_ms;
    } item_t;

    typedef struct packed {
        logic [9:0]         demand_temp;
        logic signed [10:0] demand_humid;
        logic [9:0]         want;
    } demand_t;

    typedef struct packed {
        logic [1:0]         vent_action;
        logic signed [10:0] vent_target;
        logic [3:0]         reason_flags;
    } decision_t;

endpackage

@@ rtl/graded_vent_aperture_positioner.sv @@
// Graded vent aperture positioner.
// Input items arrive on s_tvalid/s_tready/s_tdata with the temperature valid
// flag on s_tuser; each item gives exactly one result on m_tvalid/m_tready,
// with the decision and demands on m_tdata and demands_valid on m_tuser.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the temperature limit (index 0) and the arrival dead zone (index 1); it is
// always ready and is meant to be used while no item is in flight.
// An accepted item is captured in an input register, evaluated by compare,
// clamp and constant-multiply logic and stored in the result register when it
// is free or being emptied, raising m_tvalid. One item per cycle is sustained
// while m_tready is high; the single held-target register is read and updated
// in the same cycle, so consecutive items see each other's effect directly.
// When the receiver stalls, the result register holds its item and the input
// register takes one more; after that s_tready drops until m_tready returns.
// Reset (rst_n low, asynchronous) empties both registers, sets the limit to
// 25.0 degrees, the dead zone to zero and clears the held target.
module graded_vent_aperture_positioner
    import gvap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] temp_avg_c10, [14:12] law_step, [16:15] humid_demand, [17] vent_linear,
    // [29:18] pos_x10, [53:30] report_age_ms, [55:54] window_state,
    // [57:56] drive_outcome, [81:58] since_drive_ms, [87:82] zero
    input  logic [87:0] s_tdata,
    // [0] temp_valid
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] vent_action, [12:2] vent_target, [16:13] reason_flags,
    // [26:17] demand_temp, [37:27] demand_humid, [39:38] zero
    output logic [39:0] m_tdata,
    // [0] demands_valid
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic               in_valid_reg;
    item_t              in_item_reg;
    item_t              in_item;
    logic               advance;

    logic signed [11:0] temp_max_reg;
    logic [9:0]         deadzone_reg;

    demand_t            demand;
    decision_t          decision;

    logic               out_valid_reg;
    decision_t          out_dec_reg;
    logic               out_dvalid_reg;
    logic [9:0]         out_temp_reg;
    logic signed [10:0] out_humid_reg;

    // Unpack the incoming item
    always_comb
    begin
        in_item.temp_valid     = s_tuser;
        in_item.temp_avg_c10   = $signed(s_tdata[11:0]);
        in_item.law_step       = s_tdata[14:12];
        in_item.humid_demand   = s_tdata[16:15];
        in_item.vent_linear    = s_tdata[17];
        in_item.pos_x10        = $signed(s_tdata[29:18]);
        in_item.report_age_ms  = s_tdata[53:30];
        in_item.window_state   = s_tdata[55:54];
        in_item.drive_outcome  = s_tdata[57:56];
        in_item.since_drive_ms = s_tdata[81:58];
    end

    // Move an item on when the result register is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_max_reg <= TEMP_MAX_RESET;
            deadzone_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TEMP_MAX)
            begin
                temp_max_reg <= $signed(cfg_data);
            end
            else if (cfg_index == CFG_DEADZONE)
            begin
                deadzone_reg <= cfg_data[9:0];
            end
        end
    end

    gvap_demand u_demand (
        .item         (in_item_reg),
        .temp_max_c10 (temp_max_reg),
        .demand       (demand)
    );

    gvap_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .item         (in_item_reg),
        .want         (demand.want),
        .deadzone_x10 (deadzone_reg),
        .decision     (decision)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dec_reg    <= decision;
            out_dvalid_reg <= in_item_reg.temp_valid;
            out_temp_reg   <= demand.demand_temp;
            out_humid_reg  <= demand.demand_humid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dvalid_reg;
    assign m_tdata  = {2'b00, out_humid_reg, out_temp_reg, out_dec_reg.reason_flags,
                       out_dec_reg.vent_target, out_dec_reg.vent_action};

    // An item moved on always shows up as a result
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item not presented");

    // A waiting input item stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("waiting item lost");

    // Only a drive carries a target
    a_target_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_dec_reg.vent_action != ACT_DRIVE))
        |-> (out_dec_reg.vent_target == $signed(TARGET_NONE)))
        else $error("target without drive");

    // Results without valid demands carry no reason
    a_no_demand: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_dvalid_reg)
        |-> (out_dec_reg.reason_flags == '0 && out_dec_reg.vent_action == ACT_STEPPED))
        else $error("decision without valid temperature");

endmodule

@@ rtl/gvap_demand.sv @@
module gvap_demand
    import gvap_pkg::*;
(
    input  item_t          item,
    input  logic signed [11:0] temp_max_c10,
    output demand_t        demand
);

    logic signed [13:0] excess;
    logic [10:0]        prod;
    logic [9:0]         a_t;
    logic signed [10:0] a_rh;

    // Excess above the start of the aperture ramp
    assign excess = 14'(item.temp_avg_c10) - 14'(temp_max_c10) - 14'(START_C10);
    assign prod   = 11'(excess[4:0]) * 11'(APER_GAIN);

    // Clamp the ramp to closed and fully open
    always_comb
    begin
        if (excess <= 14'sd0)
        begin
            a_t = '0;
        end
        else if (excess >= 14'(APER_SPAN))
        begin
            a_t = APER_FULL;
        end
        else
        begin
            a_t = prod[9:0];
        end
    end

    // Humidity aperture; code three counts as the full step
    always_comb
    begin
        if (item.humid_demand == HUM_NONE)
        begin
            a_rh = $signed(TARGET_NONE);
        end
        else if (item.humid_demand == HUM_PARTIAL)
        begin
            a_rh = '0;
        end
        else
        begin
            a_rh = $signed({1'b0, APER_FULL});
        end
    end

    // Report zero demands when the temperature is not valid
    always_comb
    begin
        demand.demand_temp  = '0;
        demand.demand_humid = '0;
        demand.want         = '0;
        if (item.temp_valid)
        begin
            demand.demand_temp  = a_t;
            demand.demand_humid = a_rh;
            if (item.law_step >= STEP_ACTIVE)
            begin
                demand.want = (a_rh > $signed({1'b0, a_t})) ? a_rh[9:0] : a_t;
            end
        end
    end

endmodule

@@ rtl/gvap_track.sv @@
module gvap_track
    import gvap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  item_t      item,
    input  logic [9:0] want,
    input  logic [9:0] deadzone_x10,
    output decision_t  decision
);

    logic [9:0]         held_target_reg;
    logic [9:0]         held_target_next;
    logic               target_held_reg;
    logic               target_held_next;

    logic               untrusted;
    logic               rebase;
    logic [9:0]         pos_u;
    logic [9:0]         base;
    logic signed [10:0] gap;
    logic signed [10:0] gap_abs;
    logic               worth;
    logic signed [10:0] step;
    logic signed [11:0] moved;
    logic signed [10:0] off;
    logic signed [10:0] off_abs;

    assign pos_u     = item.pos_x10[9:0];
    assign untrusted = item.pos_x10[11] || (item.pos_x10 > POS_MAX)
                       || (item.report_age_ms > STALE_MS)
                       || (item.window_state == WIN_UNKNOWN);
    assign rebase    = (item.drive_outcome == RES_TIMEOUT)
                       || (item.drive_outcome == RES_ABORTED);

    // Rebase to the reported position when needed, then take the gap
    assign base    = (rebase || !target_held_reg) ? pos_u : held_target_reg;
    assign gap     = $signed({1'b0, want}) - $signed({1'b0, base});
    assign gap_abs = gap[10] ? -gap : gap;
    assign worth   = (gap_abs >= MOVE_MIN)
                     || ((gap != 11'sd0) && ((want == '0) || (want == APER_FULL)));

    // Limit one move to the step size
    always_comb
    begin
        if (gap > STEP_MAX)
        begin
            step = STEP_MAX;
        end
        else if (gap < -STEP_MAX)
        begin
            step = -STEP_MAX;
        end
        else
        begin
            step = gap;
        end
    end

    always_comb
    begin
        moved = $signed({2'b00, base});
        if (worth && (item.since_drive_ms >= HOLD_MS))
        begin
            moved = $signed({2'b00, base}) + 12'(step);
        end
    end

    assign off     = $signed({1'b0, moved[9:0]}) - $signed({1'b0, pos_u});
    assign off_abs = off[10] ? -off : off;

    // Decide the action and the next held target
    always_comb
    begin
        decision.vent_action  = ACT_STEPPED;
        decision.vent_target  = $signed(TARGET_NONE);
        decision.reason_flags = '0;
        held_target_next      = held_target_reg;
        target_held_next      = target_held_reg;
        if (item.temp_valid)
        begin
            if (!item.vent_linear)
            begin
                decision.reason_flags[FL_DIGITAL] = 1'b1;
            end
            else
            begin
                decision.vent_action = ACT_HOLD;
                if (untrusted)
                begin
                    decision.reason_flags[FL_NO_POS] = 1'b1;
                end
                else if (item.window_state != WIN_REST)
                begin
                    if (target_held_reg)
                    begin
                        decision.vent_action = ACT_DRIVE;
                        decision.vent_target = $signed({1'b0, held_target_reg});
                    end
                end
                else
                begin
                    decision.reason_flags[FL_REBASED] = rebase;
                    decision.reason_flags[FL_HELD]    = worth
                                                        && (item.since_drive_ms < HOLD_MS);
                    held_target_next = moved[9:0];
                    target_held_next = 1'b1;
                    if (off_abs > $signed({1'b0, deadzone_x10}))
                    begin
                        decision.vent_action = ACT_DRIVE;
                        decision.vent_target = $signed({1'b0, moved[9:0]});
                    end
                end
            end
        end
    end

    // Hold the target between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_target_reg <= '0;
            target_held_reg <= 1'b0;
        end
        else if (en)
        begin
            held_target_reg <= held_target_next;
            target_held_reg <= target_held_next;
        end
    end

    // A held target never leaves the travel range
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        target_held_reg |-> (held_target_reg <= APER_FULL))
        else $error("held target out of range");

    // Once a target is held it stays held
    a_held_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        target_held_reg |=> target_held_reg)
        else $error("held target lost");

endmodule
